[hw/rtl/pffr_pkg.sv]
// pffr_pkg: item types, register indexes, result codes and the control store
// of the page fault frame replacer. No dependencies.
package pffr_pkg;

  localparam int FAULT_PAGE_W  = 10;
  localparam int RANDOM_PICK_W = 6;
  localparam int FRAME_W       = 6;
  localparam int FRAME_COUNT_W = 7;
  localparam int CFG_INDEX_W   = 1;
  localparam int K_W           = 4;
  localparam int PICK_K0       = RANDOM_PICK_W - 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 1'd1;

  localparam logic                     POLICY_RANDOM   = 1'b0;
  localparam logic                     POLICY_RST      = 1'b1;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 7'd64;

  // result actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_REPLACE = 2'd1;
  localparam logic [1:0] ACT_WRITE   = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  typedef struct packed {
    logic [FAULT_PAGE_W-1:0]  fault_page;
    logic [RANDOM_PICK_W-1:0] random_pick;
  } fault_in_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [FRAME_W-1:0]      frame;
    logic                    read_in;
    logic                    write_back;
    logic                    evicted_valid;
    logic [FAULT_PAGE_W-1:0] evicted_page;
    logic                    read_ok;
    logic                    write_ok;
  } fault_out_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_EMIT,
    UOP_WAIT_IN,
    UOP_REDUCE,
    UOP_PAGE_RD,
    UOP_PAGE_CHK,
    UOP_LOAD_FREE,
    UOP_HEAD_PREP,
    UOP_HEAD_SET,
    UOP_TAIL_SET,
    UOP_EV_FETCH,
    UOP_EV_CLEAR,
    UOP_MAP_NEW,
    UOP_RAND_PREP,
    UOP_RAND_SET,
    UOP_GRANT
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_K_NZ,
    C_MAPPED,
    C_NOT_FREE,
    C_RANDOM,
    C_ACT_FREE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  // step addresses
  localparam upc_t ST_EMIT     = 5'd0;
  localparam upc_t ST_IDLE     = 5'd1;
  localparam upc_t ST_MOD_PAGE = 5'd2;
  localparam upc_t ST_PAGE_RD  = 5'd3;
  localparam upc_t ST_PAGE_CHK = 5'd4;
  localparam upc_t ST_FREE_CHK = 5'd5;
  localparam upc_t ST_LOAD     = 5'd6;
  localparam upc_t ST_REPL     = 5'd7;
  localparam upc_t ST_HEAD_PRE = 5'd8;
  localparam upc_t ST_MOD_HEAD = 5'd9;
  localparam upc_t ST_HEAD_SET = 5'd10;
  localparam upc_t ST_MOD_TAIL = 5'd11;
  localparam upc_t ST_TAIL_SET = 5'd12;
  localparam upc_t ST_EV_WAIT  = 5'd13;
  localparam upc_t ST_EV_FETCH = 5'd14;
  localparam upc_t ST_EV_CLEAR = 5'd15;
  localparam upc_t ST_MAP_NEW  = 5'd16;
  localparam upc_t ST_RAND_PRE = 5'd17;
  localparam upc_t ST_MOD_RAND = 5'd18;
  localparam upc_t ST_RAND_SET = 5'd19;
  localparam upc_t ST_GRANT    = 5'd20;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{op: UOP_NOP, cond: C_ALWAYS, target: ST_IDLE};
    unique case (pc)
      ST_EMIT:     w = '{op: UOP_EMIT,      cond: C_OUT_BUSY, target: ST_EMIT};
      ST_IDLE:     w = '{op: UOP_WAIT_IN,   cond: C_NO_IN,    target: ST_IDLE};
      ST_MOD_PAGE: w = '{op: UOP_REDUCE,    cond: C_K_NZ,     target: ST_MOD_PAGE};
      ST_PAGE_RD:  w = '{op: UOP_PAGE_RD,   cond: C_NEVER,    target: ST_IDLE};
      ST_PAGE_CHK: w = '{op: UOP_PAGE_CHK,  cond: C_MAPPED,   target: ST_GRANT};
      ST_FREE_CHK: w = '{op: UOP_NOP,       cond: C_NOT_FREE, target: ST_REPL};
      ST_LOAD:     w = '{op: UOP_LOAD_FREE, cond: C_ALWAYS,   target: ST_MOD_TAIL};
      ST_REPL:     w = '{op: UOP_NOP,       cond: C_RANDOM,   target: ST_RAND_PRE};
      ST_HEAD_PRE: w = '{op: UOP_HEAD_PREP, cond: C_NEVER,    target: ST_IDLE};
      ST_MOD_HEAD: w = '{op: UOP_REDUCE,    cond: C_K_NZ,     target: ST_MOD_HEAD};
      ST_HEAD_SET: w = '{op: UOP_HEAD_SET,  cond: C_NEVER,    target: ST_IDLE};
      ST_MOD_TAIL: w = '{op: UOP_REDUCE,    cond: C_K_NZ,     target: ST_MOD_TAIL};
      ST_TAIL_SET: w = '{op: UOP_TAIL_SET,  cond: C_ACT_FREE, target: ST_MAP_NEW};
      ST_EV_WAIT:  w = '{op: UOP_NOP,       cond: C_NEVER,    target: ST_IDLE};
      ST_EV_FETCH: w = '{op: UOP_EV_FETCH,  cond: C_NEVER,    target: ST_IDLE};
      ST_EV_CLEAR: w = '{op: UOP_EV_CLEAR,  cond: C_NEVER,    target: ST_IDLE};
      ST_MAP_NEW:  w = '{op: UOP_MAP_NEW,   cond: C_ALWAYS,   target: ST_EMIT};
      ST_RAND_PRE: w = '{op: UOP_RAND_PREP, cond: C_NEVER,    target: ST_IDLE};
      ST_MOD_RAND: w = '{op: UOP_REDUCE,    cond: C_K_NZ,     target: ST_MOD_RAND};
      ST_RAND_SET: w = '{op: UOP_RAND_SET,  cond: C_ALWAYS,   target: ST_EV_WAIT};
      ST_GRANT:    w = '{op: UOP_GRANT,     cond: C_ALWAYS,   target: ST_EMIT};
      default:     w = '{op: UOP_NOP,       cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/page_fault_frame_replacer.sv]
// page_fault_frame_replacer: top level, microcoded sequencer over page table,
// frame owner and fifo ring memories. Depends on pffr_pkg and pffr_ram.

// After reset the block clears the page table and the frame owner table,
// stepping a counter up to the larger of PAGE_COUNT and MAX_FRAMES, and
// takes no item in that time; configuration writes are taken at once. Each
// item then runs through a short control program: a fault on a mapped page
// takes the shortest path, a load into a free frame a longer one, a random
// replacement a longer one still and a fifo replacement the longest, each
// plus any wait for the output to drain.
// The path length is set by the shared remainder unit, which settles one
// quotient bit per cycle for the page number, the random pick and each ring
// pointer advance, and by the registered reads of the page table. A result
// sits in an output register, so the next item is taken while it waits.
module page_fault_frame_replacer #(
  parameter int PAGE_COUNT = 1024,
  parameter int MAX_FRAMES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  pffr_pkg::fault_in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pffr_pkg::fault_out_t                 out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pffr_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [pffr_pkg::FRAME_COUNT_W-1:0]   cfg_data_i
);

  localparam int PW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FW        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW        = $clog2(MAX_FRAMES + 1);
  localparam int MW        = FW + 2;
  localparam int PCW       = $clog2(PAGE_COUNT + 1);
  localparam int RwA       = (PCW > pffr_pkg::FAULT_PAGE_W) ? PCW : pffr_pkg::FAULT_PAGE_W;
  localparam int RW        = (NW > RwA) ? NW : RwA;
  localparam int KW        = pffr_pkg::K_W;
  localparam int SW        = RW + (1 << KW);
  localparam int FrameW    = pffr_pkg::FRAME_W;
  localparam int PageW     = pffr_pkg::FAULT_PAGE_W;
  localparam int PageSpan  = (1 << pffr_pkg::FAULT_PAGE_W) / PAGE_COUNT;
  localparam int PageStepA = $clog2(PageSpan + 1);
  localparam int PageSteps = (PageStepA > 1) ? PageStepA : 1;
  localparam int ClrLen    = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
  localparam int CW        = (ClrLen > 1) ? $clog2(ClrLen) : 1;
  localparam int WrBit     = 0;
  localparam int RdBit     = 1;

  localparam logic [KW-1:0] PageK0 = KW'(PageSteps - 1);
  localparam logic [KW-1:0] PickK0 = KW'(pffr_pkg::PICK_K0);
  localparam logic [KW-1:0] PosK0  = KW'(NW - 1);

  // sequencer and control state
  pffr_pkg::upc_t   pc_q, pc_d;
  pffr_pkg::uword_t uword;
  logic             cond_hit;
  logic             clr_q, clr_d;
  logic [CW-1:0]    clr_cnt_q, clr_cnt_d;
  logic             policy_q, policy_d;
  logic [pffr_pkg::FRAME_COUNT_W-1:0] count_q, count_d;
  logic [NW-1:0]    filled_q, filled_d;
  logic [FW-1:0]    head_q, head_d;
  logic [FW-1:0]    tail_q, tail_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic [RW-1:0]    r_q, r_d;
  logic [RW-1:0]    dvs_q, dvs_d;
  logic [KW-1:0]    k_q, k_d;
  logic [SW-1:0]    r_ext, dsh;
  logic [NW-1:0]    n_q, n_d, n_cfg;
  logic [PW-1:0]    page_q, page_d;
  logic [pffr_pkg::RANDOM_PICK_W-1:0] pick_q, pick_d;
  logic [MW-1:0]    entry_q, entry_d;
  logic [FW-1:0]    frame_q, frame_d;
  logic [PW-1:0]    ev_page_q, ev_page_d;
  logic [1:0]       action_q, action_d;
  logic             read_in_q, read_in_d;
  logic             wb_q, wb_d;
  logic             ev_valid_q, ev_valid_d;
  logic             rd_ok_q, rd_ok_d;
  logic             wr_ok_q, wr_ok_d;
  pffr_pkg::fault_out_t out_q, out_d;
  logic             in_acc, out_busy;

  // memory ports
  logic          map_we;
  logic [PW-1:0] map_waddr, map_raddr;
  logic [MW-1:0] map_wdata, map_rdata;
  logic          own_we;
  logic [FW-1:0] own_waddr;
  logic [PW-1:0] own_wdata, own_rdata;
  logic          ring_we;
  logic [FW-1:0] ring_wdata, ring_rdata;

  pffr_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_page_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  pffr_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (frame_q),
    .rdata_o (own_rdata)
  );

  pffr_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_fifo_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (tail_q),
    .wdata_i (ring_wdata),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  assign in_ready_o  = !clr_q && (pc_q == pffr_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    uword    = pffr_pkg::ucode_rom(pc_q);
    in_acc   = in_valid_i && in_ready_o;
    out_busy = out_valid_q && !out_ready_i;

    if (count_q == '0) begin
      n_cfg = NW'(1);
    end else if (int'(count_q) > MAX_FRAMES) begin
      n_cfg = NW'(MAX_FRAMES);
    end else begin
      n_cfg = NW'(count_q);
    end

    r_ext = SW'(r_q);
    dsh   = SW'(dvs_q) << k_q;

    case (uword.cond)
      pffr_pkg::C_NEVER:    cond_hit = 1'b0;
      pffr_pkg::C_ALWAYS:   cond_hit = 1'b1;
      pffr_pkg::C_NO_IN:    cond_hit = !in_acc;
      pffr_pkg::C_K_NZ:     cond_hit = (k_q != '0);
      pffr_pkg::C_MAPPED:   cond_hit = map_rdata[RdBit] || map_rdata[WrBit];
      pffr_pkg::C_NOT_FREE: cond_hit = (filled_q >= n_q);
      pffr_pkg::C_RANDOM:   cond_hit = (policy_q == pffr_pkg::POLICY_RANDOM);
      pffr_pkg::C_ACT_FREE: cond_hit = (action_q == pffr_pkg::ACT_LOAD);
      pffr_pkg::C_OUT_BUSY: cond_hit = out_busy;
      default:              cond_hit = 1'b0;
    endcase

    pc_d        = cond_hit ? uword.target : pffr_pkg::upc_t'(pc_q + 1'b1);
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    policy_d    = policy_q;
    count_d     = count_q;
    filled_d    = filled_q;
    head_d      = head_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q;
    r_d         = r_q;
    dvs_d       = dvs_q;
    k_d         = k_q;
    n_d         = n_q;
    page_d      = page_q;
    pick_d      = pick_q;
    entry_d     = entry_q;
    frame_d     = frame_q;
    ev_page_d   = ev_page_q;
    action_d    = action_q;
    read_in_d   = read_in_q;
    wb_d        = wb_q;
    ev_valid_d  = ev_valid_q;
    rd_ok_d     = rd_ok_q;
    wr_ok_d     = wr_ok_q;
    out_d       = out_q;

    map_we     = 1'b0;
    map_waddr  = page_q;
    map_wdata  = '0;
    map_raddr  = page_q;
    own_we     = 1'b0;
    own_waddr  = frame_q;
    own_wdata  = page_q;
    ring_we    = 1'b0;
    ring_wdata = frame_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (uword.op)
      pffr_pkg::UOP_NOP: ;
      pffr_pkg::UOP_EMIT: begin
        if (!out_busy) begin
          out_valid_d         = 1'b1;
          out_d.action        = action_q;
          out_d.frame         = FrameW'(frame_q);
          out_d.read_in       = read_in_q;
          out_d.write_back    = wb_q;
          out_d.evicted_valid = ev_valid_q;
          out_d.evicted_page  = PageW'(ev_page_q);
          out_d.read_ok       = rd_ok_q;
          out_d.write_ok      = wr_ok_q;
        end
      end
      pffr_pkg::UOP_WAIT_IN: begin
        if (in_acc) begin
          r_d        = RW'(in_data_i.fault_page);
          dvs_d      = RW'(PAGE_COUNT);
          k_d        = PageK0;
          pick_d     = in_data_i.random_pick;
          n_d        = n_cfg;
          read_in_d  = 1'b0;
          wb_d       = 1'b0;
          ev_valid_d = 1'b0;
          ev_page_d  = '0;
        end
      end
      pffr_pkg::UOP_REDUCE: begin
        // restoring remainder, one quotient bit per step
        if (r_ext >= dsh) begin
          r_d = RW'(r_ext - dsh);
        end
        k_d = k_q - 1'b1;
      end
      pffr_pkg::UOP_PAGE_RD: begin
        page_d    = PW'(r_q);
        map_raddr = PW'(r_q);
      end
      pffr_pkg::UOP_PAGE_CHK: begin
        entry_d = map_rdata;
      end
      pffr_pkg::UOP_LOAD_FREE: begin
        frame_d    = filled_q[FW-1:0];
        filled_d   = filled_q + 1'b1;
        ring_we    = 1'b1;
        ring_wdata = filled_q[FW-1:0];
        action_d   = pffr_pkg::ACT_LOAD;
        read_in_d  = 1'b1;
        r_d        = RW'(tail_q) + RW'(1);
        dvs_d      = RW'(n_q);
        k_d        = PosK0;
      end
      pffr_pkg::UOP_HEAD_PREP: begin
        action_d  = pffr_pkg::ACT_REPLACE;
        read_in_d = 1'b1;
        r_d       = RW'(head_q) + RW'(1);
        dvs_d     = RW'(n_q);
        k_d       = PosK0;
      end
      pffr_pkg::UOP_HEAD_SET: begin
        // ring data still belongs to the old head
        head_d     = r_q[FW-1:0];
        frame_d    = ring_rdata;
        ring_we    = 1'b1;
        ring_wdata = ring_rdata;
        r_d        = RW'(tail_q) + RW'(1);
        dvs_d      = RW'(n_q);
        k_d        = PosK0;
      end
      pffr_pkg::UOP_TAIL_SET: begin
        tail_d = r_q[FW-1:0];
      end
      pffr_pkg::UOP_EV_FETCH: begin
        ev_page_d = own_rdata;
        map_raddr = own_rdata;
      end
      pffr_pkg::UOP_EV_CLEAR: begin
        wb_d       = map_rdata[WrBit];
        ev_valid_d = 1'b1;
        map_we     = 1'b1;
        map_waddr  = ev_page_q;
        map_wdata  = '0;
      end
      pffr_pkg::UOP_MAP_NEW: begin
        map_we    = 1'b1;
        map_waddr = page_q;
        map_wdata = {frame_q, 1'b1, 1'b0};
        own_we    = 1'b1;
        own_waddr = frame_q;
        own_wdata = page_q;
        rd_ok_d   = 1'b1;
        wr_ok_d   = 1'b0;
      end
      pffr_pkg::UOP_RAND_PREP: begin
        action_d  = pffr_pkg::ACT_REPLACE;
        read_in_d = 1'b1;
        r_d       = RW'(pick_q);
        dvs_d     = RW'(n_q);
        k_d       = PickK0;
      end
      pffr_pkg::UOP_RAND_SET: begin
        frame_d = r_q[FW-1:0];
      end
      pffr_pkg::UOP_GRANT: begin
        frame_d   = entry_q[MW-1:2];
        map_we    = 1'b1;
        map_waddr = page_q;
        if (entry_q[RdBit] && !entry_q[WrBit]) begin
          action_d  = pffr_pkg::ACT_WRITE;
          map_wdata = {entry_q[MW-1:2], 1'b1, 1'b1};
          rd_ok_d   = 1'b1;
          wr_ok_d   = 1'b1;
        end else begin
          action_d  = pffr_pkg::ACT_READ;
          map_wdata = {entry_q[MW-1:2], 1'b1, entry_q[WrBit]};
          rd_ok_d   = 1'b1;
          wr_ok_d   = entry_q[WrBit];
        end
      end
      default: ;
    endcase

    // clearing pass after reset
    if (clr_q) begin
      map_we    = (int'(clr_cnt_q) < PAGE_COUNT);
      map_waddr = clr_cnt_q[PW-1:0];
      map_wdata = '0;
      own_we    = (int'(clr_cnt_q) < MAX_FRAMES);
      own_waddr = clr_cnt_q[FW-1:0];
      own_wdata = '0;
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == CW'(ClrLen - 1)) begin
        clr_d = 1'b0;
      end
    end

    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pffr_pkg::REG_POLICY:      policy_d = cfg_data_i[0];
        pffr_pkg::REG_FRAME_COUNT: count_d  = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pffr_pkg::ST_IDLE;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      policy_q    <= pffr_pkg::POLICY_RST;
      count_q     <= pffr_pkg::FRAME_COUNT_RST;
      filled_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      policy_q    <= policy_d;
      count_q     <= count_d;
      filled_q    <= filled_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    dvs_q      <= dvs_d;
    k_q        <= k_d;
    n_q        <= n_d;
    page_q     <= page_d;
    pick_q     <= pick_d;
    entry_q    <= entry_d;
    frame_q    <= frame_d;
    ev_page_q  <= ev_page_d;
    action_q   <= action_d;
    read_in_q  <= read_in_d;
    wb_q       <= wb_d;
    ev_valid_q <= ev_valid_d;
    rd_ok_q    <= rd_ok_d;
    wr_ok_q    <= wr_ok_d;
    out_q      <= out_d;
  end

  // frames filled never passes the number of physical frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(filled_q) <= MAX_FRAMES)
    else $error("frames filled count overran");

  // ring pointers always stay inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(head_q) < MAX_FRAMES) && (int'(tail_q) < MAX_FRAMES))
    else $error("fifo ring pointer out of range");

  // a replacement always unmaps a victim and reads the new page in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == pffr_pkg::ACT_REPLACE)
    |-> out_data_o.evicted_valid && out_data_o.read_in)
    else $error("replacement item without eviction");

  // an access grant touches neither backing store nor any other page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.action == pffr_pkg::ACT_WRITE) ||
                    (out_data_o.action == pffr_pkg::ACT_READ))
    |-> !out_data_o.read_in && !out_data_o.evicted_valid && !out_data_o.write_back)
    else $error("grant item with paging side effect");

endmodule

[hw/rtl/pffr_ram.sv]
// pffr_ram: generic single write port, single read port memory with
// registered read data. No dependencies.
module pffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
